@@ rtl/string_to_integer_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// String-to-integer parser assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STRING_TO_INTEGER_PARSER_UNIT_ASSERT_SVH
`define STRING_TO_INTEGER_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define STOI_ASSERT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stoi assertion failed");

// next-cycle implication
`define STOI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stoi assertion failed");

`endif

@@ rtl/stoi_pkg.sv @@
// ----------------------------------------------------------------------------
// String-to-integer parser package
// Widths, codes, character constants, item types and the digit decoder.
// ----------------------------------------------------------------------------
package stoi_pkg;

    localparam int CH_W       = 8;
    localparam int OFF_W      = 16;
    localparam int VAL_W      = 64;
    localparam int ST_W       = 2;
    localparam int BASE_W     = 6;
    localparam int DIG_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [OFF_W-1:0] MAX_LEN = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW = 1'd1;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADBASE = 2'd2;

    localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

    localparam logic [DIG_W-1:0] DIGIT_NONE = 6'h3F;
    localparam logic [DIG_W-1:0] DIGIT_TEN  = 6'd10;

    localparam logic [CH_W-1:0] CHR_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CHR_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CHR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHR_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CHR_A_UP  = 8'h41;
    localparam logic [CH_W-1:0] CHR_X_UP  = 8'h58;
    localparam logic [CH_W-1:0] CHR_Z_UP  = 8'h5A;
    localparam logic [CH_W-1:0] CHR_A_LO  = 8'h61;
    localparam logic [CH_W-1:0] CHR_X_LO  = 8'h78;
    localparam logic [CH_W-1:0] CHR_Z_LO  = 8'h7A;

    typedef enum logic [2:0] {
        PH_SIGN,
        PH_FIRST,
        PH_ZERO,
        PH_ZEROX,
        PH_DIGITS,
        PH_DONE,
        PH_BADBASE
    } phase_t;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic              narrow;
    } cfg_t;

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic             is_nul;
        logic             is_minus;
        logic             is_plus;
        logic             is_zero;
        logic             is_x;
        logic             last;
        logic             in_range;
        logic [OFF_W-1:0] idx;
    } item_t;

    function automatic logic [DIG_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [CH_W-1:0] d;
        d = {2'b00, DIGIT_NONE};
        if (c >= CHR_ZERO && c <= CHR_NINE)
        begin
            d = c - CHR_ZERO;
        end
        else if (c >= CHR_A_UP && c <= CHR_Z_UP)
        begin
            d = c - CHR_A_UP + {2'b00, DIGIT_TEN};
        end
        else if (c >= CHR_A_LO && c <= CHR_Z_LO)
        begin
            d = c - CHR_A_LO + {2'b00, DIGIT_TEN};
        end
        return d[DIG_W-1:0];
    endfunction

endpackage

@@ rtl/stoi_if.sv @@
// ----------------------------------------------------------------------------
// String-to-integer parser channels
// Character channel and result channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface stoi_in_if;
    import stoi_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, ch, last, input ready);
    modport sink   (input valid, ch, last, output ready);
endinterface

interface stoi_out_if;
    import stoi_pkg::*;

    logic             valid;
    logic             ready;
    logic             negative;
    logic [VAL_W-1:0] value;
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] end_offset;

    modport source (output valid, negative, value, status, end_offset, input ready);
    modport sink   (input valid, negative, value, status, end_offset, output ready);
endinterface

@@ rtl/stoi_front.sv @@
// ----------------------------------------------------------------------------
// String-to-integer parser front end
// Accepts characters, decodes them into class flags and a digit value, and
// tags each with its position in the string.
// ----------------------------------------------------------------------------
module stoi_front (
    input  logic            clk,
    input  logic            rst_n,
    stoi_in_if.sink         req,
    input  logic            full,
    output logic            push,
    output stoi_pkg::item_t item
);
    import stoi_pkg::*;

    logic [OFF_W-1:0] idx_reg;
    logic [OFF_W-1:0] idx_next;
    logic             in_range;

    assign req.ready = !full;
    assign push      = req.valid && !full;
    assign in_range  = idx_reg < MAX_LEN;

    always_comb
    begin
        item.digit    = digit_of(req.ch);
        item.is_nul   = req.ch == CHR_NUL;
        item.is_minus = req.ch == CHR_MINUS;
        item.is_plus  = req.ch == CHR_PLUS;
        item.is_zero  = req.ch == CHR_ZERO;
        item.is_x     = (req.ch == CHR_X_LO) || (req.ch == CHR_X_UP);
        item.last     = req.last;
        item.in_range = in_range;
        item.idx      = idx_reg;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (push)
        begin
            if (req.last)
            begin
                idx_next = '0;
            end
            else if (in_range)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ rtl/stoi_queue.sv @@
// ----------------------------------------------------------------------------
// String-to-integer parser item queue
// Small FIFO of decoded characters between front end and back end.
// ----------------------------------------------------------------------------
module stoi_queue #(
    parameter int DEPTH = stoi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  stoi_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output stoi_pkg::item_t q_item
);
    import stoi_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/stoi_back.sv @@
// ----------------------------------------------------------------------------
// String-to-integer parser back end
// Runs the sign, prefix and digit phases, accumulates value * base + digit
// and registers one result per string.
// ----------------------------------------------------------------------------
module stoi_back (
    input  logic            clk,
    input  logic            rst_n,
    input  stoi_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  stoi_pkg::item_t q_item,
    output logic            pop,
    stoi_out_if.source      rsp
);
    import stoi_pkg::*;

    localparam int PROD_W = VAL_W + BASE_W;

    phase_t            phase_reg;
    phase_t            phase_next;
    phase_t            phase_proc;
    phase_t            phase_eff;
    logic [VAL_W-1:0]  acc_reg;
    logic [VAL_W-1:0]  acc_next;
    logic [VAL_W-1:0]  acc_proc;
    logic              neg_reg;
    logic              neg_next;
    logic              neg_proc;
    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] base_next;
    logic [BASE_W-1:0] base_proc;
    logic [OFF_W-1:0]  stop_reg;
    logic [OFF_W-1:0]  stop_next;
    logic [OFF_W-1:0]  stop_proc;
    logic              ovf_reg;
    logic              ovf_next;
    logic              ovf_proc;

    logic              res_valid_reg;
    logic              res_valid_next;
    logic              res_neg_reg;
    logic              res_neg_next;
    logic [VAL_W-1:0]  res_val_reg;
    logic [VAL_W-1:0]  res_val_next;
    logic [ST_W-1:0]   res_st_reg;
    logic [ST_W-1:0]   res_st_next;
    logic [OFF_W-1:0]  res_off_reg;
    logic [OFF_W-1:0]  res_off_next;

    logic              fire;
    logic [BASE_W-1:0] b_fc;
    logic              bad_base;
    logic              fc_zpfx;
    logic [BASE_W-1:0] fc_base;
    logic              fc_ok;
    logic              ds_stop;
    logic              do_first;
    logic              do_digit;
    logic              hex_ok;
    logic [PROD_W-1:0] prod;
    logic              mul_ovf;
    logic [OFF_W-1:0]  cidx;

    assign pop  = q_valid && (!q_item.last || !res_valid_reg || rsp.ready);
    assign fire = pop;

    assign b_fc     = (phase_reg == PH_SIGN) ? cfg.base : base_reg;
    assign bad_base = (cfg.base == BASE_ONE) || (cfg.base > BASE_MAX);
    assign fc_zpfx  = ((b_fc == BASE_AUTO) || (b_fc == BASE_HEX)) && q_item.is_zero;
    assign fc_base  = (b_fc == BASE_AUTO) ? BASE_DEC : b_fc;
    assign fc_ok    = !q_item.is_nul && (q_item.digit < fc_base);
    assign ds_stop  = q_item.is_nul || (q_item.digit >= base_reg);
    assign hex_ok   = q_item.digit < BASE_HEX;
    assign do_first = ((phase_reg == PH_SIGN) && !bad_base && !q_item.is_minus
                       && !q_item.is_plus) || (phase_reg == PH_FIRST);
    assign do_digit = ((phase_reg == PH_ZERO) && !q_item.is_x) || (phase_reg == PH_DIGITS);
    assign prod     = PROD_W'(acc_reg) * PROD_W'(base_reg) + PROD_W'(q_item.digit);
    assign mul_ovf  = |prod[PROD_W-1:VAL_W];
    assign cidx     = q_item.in_range ? q_item.idx + 1'b1 : q_item.idx;

    // next phase
    always_comb
    begin
        case (phase_reg)
            PH_SIGN:
            begin
                if (bad_base)
                    phase_proc = PH_BADBASE;
                else if (q_item.is_minus || q_item.is_plus)
                    phase_proc = PH_FIRST;
                else if (fc_zpfx)
                    phase_proc = PH_ZERO;
                else if (fc_ok)
                    phase_proc = PH_DIGITS;
                else
                    phase_proc = PH_DONE;
            end
            PH_FIRST:
            begin
                if (fc_zpfx)
                    phase_proc = PH_ZERO;
                else if (fc_ok)
                    phase_proc = PH_DIGITS;
                else
                    phase_proc = PH_DONE;
            end
            PH_ZERO:
            begin
                if (q_item.is_x)
                    phase_proc = PH_ZEROX;
                else if (ds_stop)
                    phase_proc = PH_DONE;
                else
                    phase_proc = PH_DIGITS;
            end
            PH_ZEROX:   phase_proc = hex_ok ? PH_DIGITS : PH_DONE;
            PH_DIGITS:  phase_proc = ds_stop ? PH_DONE : PH_DIGITS;
            default:    phase_proc = phase_reg;
        endcase
        phase_eff = q_item.in_range ? phase_proc : phase_reg;
        if (!fire)
            phase_next = phase_reg;
        else if (q_item.last)
            phase_next = PH_SIGN;
        else
            phase_next = phase_eff;
    end

    // datapath
    always_comb
    begin
        acc_proc  = acc_reg;
        neg_proc  = neg_reg;
        base_proc = base_reg;
        stop_proc = stop_reg;
        ovf_proc  = ovf_reg;
        if (phase_reg == PH_SIGN)
        begin
            base_proc = cfg.base;
            if (!bad_base && q_item.is_minus)
                neg_proc = 1'b1;
        end
        if (do_first)
        begin
            if (fc_zpfx)
            begin
                base_proc = (b_fc == BASE_HEX) ? BASE_HEX : BASE_OCT;
                acc_proc  = '0;
            end
            else
            begin
                base_proc = fc_base;
                if (fc_ok)
                begin
                    acc_proc = VAL_W'(q_item.digit);
                end
                else
                begin
                    acc_proc  = '0;
                    neg_proc  = 1'b0;
                    stop_proc = '0;
                    ovf_proc  = 1'b0;
                end
            end
        end
        if (do_digit)
        begin
            if (ds_stop)
                stop_proc = q_item.idx;
            else if (mul_ovf)
            begin
                acc_proc = '1;
                ovf_proc = 1'b1;
            end
            else
                acc_proc = prod[VAL_W-1:0];
        end
        if (phase_reg == PH_ZEROX)
        begin
            if (hex_ok)
            begin
                base_proc = BASE_HEX;
                acc_proc  = VAL_W'(q_item.digit);
            end
            else
            begin
                acc_proc  = '0;
                stop_proc = q_item.idx - 1'b1;
            end
        end

        acc_next  = acc_reg;
        neg_next  = neg_reg;
        base_next = base_reg;
        stop_next = stop_reg;
        ovf_next  = ovf_reg;
        if (fire)
        begin
            if (q_item.last)
            begin
                acc_next  = '0;
                neg_next  = 1'b0;
                base_next = '0;
                stop_next = '0;
                ovf_next  = 1'b0;
            end
            else if (q_item.in_range)
            begin
                acc_next  = acc_proc;
                neg_next  = neg_proc;
                base_next = base_proc;
                stop_next = stop_proc;
                ovf_next  = ovf_proc;
            end
        end
    end

    // result
    always_comb
    begin
        logic             e_neg;
        logic [VAL_W-1:0] e_acc;
        logic [OFF_W-1:0] e_stop;
        logic             e_ovf;
        e_neg  = q_item.in_range ? neg_proc : neg_reg;
        e_acc  = q_item.in_range ? acc_proc : acc_reg;
        e_stop = q_item.in_range ? stop_proc : stop_reg;
        e_ovf  = q_item.in_range ? ovf_proc : ovf_reg;

        res_neg_next = 1'b0;
        res_val_next = '0;
        res_st_next  = ST_OK;
        res_off_next = '0;
        case (phase_eff)
            PH_BADBASE:
            begin
                res_st_next = ST_BADBASE;
            end
            PH_SIGN, PH_FIRST:
            begin
                res_st_next = ST_OK;
            end
            PH_ZERO, PH_DIGITS:
            begin
                res_neg_next = e_neg;
                res_val_next = e_acc;
                res_off_next = cidx;
                res_st_next  = e_ovf ? ST_RANGE : ST_OK;
            end
            PH_ZEROX:
            begin
                res_neg_next = e_neg;
                res_off_next = cidx - 1'b1;
            end
            default:
            begin
                res_neg_next = e_neg;
                res_val_next = e_acc;
                res_off_next = e_stop;
                res_st_next  = e_ovf ? ST_RANGE : ST_OK;
            end
        endcase
        if ((res_st_next != ST_BADBASE) && cfg.narrow && (|res_val_next[VAL_W-1:32]))
        begin
            res_val_next = {{(VAL_W-32){1'b0}}, 32'hFFFF_FFFF};
            res_st_next  = ST_RANGE;
        end

        if (fire && q_item.last)
            res_valid_next = 1'b1;
        else if (rsp.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    assign rsp.valid      = res_valid_reg;
    assign rsp.negative   = res_neg_reg;
    assign rsp.value      = res_val_reg;
    assign rsp.status     = res_st_reg;
    assign rsp.end_offset = res_off_reg;

    always_ff @(posedge clk)
    begin
        if (fire && q_item.last)
        begin
            res_neg_reg <= res_neg_next;
            res_val_reg <= res_val_next;
            res_st_reg  <= res_st_next;
            res_off_reg <= res_off_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIGN;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            base_reg      <= '0;
            stop_reg      <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
            stop_reg      <= stop_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

@@ rtl/string_to_integer_parser_unit.sv @@
// ----------------------------------------------------------------------------
// String-to-integer parser unit
// Parses a character stream into sign, 64-bit magnitude, status and offset.
//
//   channel  dir  payload                                 closes on
//   req      in   ch[7:0], last                           valid && ready
//   rsp      out  negative, value[63:0], status[1:0],     valid && ready
//                 end_offset[15:0]
//   cfg      in   cfg_index selects base or narrow_mode   cfg_we
//
// One character per cycle while no held result stalls the back end;
// the back end's combinational value * base + digit step sets the rate.
// A result is valid in the cycle after its last character leaves the queue.
// Reset clears control state only; there is no clearing pass.
// The queue holds QUEUE_DEPTH characters while a result waits on rsp.ready;
// only a last character stalls the back end behind a held result.
// ----------------------------------------------------------------------------
module string_to_integer_parser_unit #(
    parameter int QUEUE_DEPTH = stoi_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [stoi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stoi_pkg::CFG_DATA_W-1:0] cfg_data,
    stoi_in_if.sink                        req,
    stoi_out_if.source                     rsp
);
    import stoi_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    item_t push_item;
    item_t q_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE:   cfg_next.base   = cfg_data[BASE_W-1:0];
                CFG_NARROW: cfg_next.narrow = cfg_data[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base   <= BASE_RESET;
            cfg_reg.narrow <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    stoi_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .full  (full),
        .push  (push),
        .item  (push_item)
    );

    stoi_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    stoi_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

@@ rtl/stoi_checker.sv @@
// ----------------------------------------------------------------------------
// String-to-integer parser port checker
// Watches the top-level ports for result ordering and range saturation.
// ----------------------------------------------------------------------------
`include "string_to_integer_parser_unit_assert.svh"

module stoi_port_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        req_last,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_negative,
    input logic [stoi_pkg::VAL_W-1:0]  rsp_value,
    input logic [stoi_pkg::ST_W-1:0]   rsp_status,
    input logic [stoi_pkg::OFF_W-1:0]  rsp_end_offset
);
    import stoi_pkg::*;

    logic [7:0] pending_reg;
    logic [7:0] pending_next;
    logic       last_acc;
    logic       rsp_acc;

    assign last_acc = req_valid && req_ready && req_last;
    assign rsp_acc  = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg + {7'd0, last_acc} - {7'd0, rsp_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `STOI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `STOI_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready,
        $stable(rsp_value) && $stable(rsp_status) && $stable(rsp_negative)
        && $stable(rsp_end_offset))
    `STOI_ASSERT(a_rsp_has_string, rsp_valid, pending_reg != 8'd0)
    `STOI_ASSERT(a_range_saturated, rsp_valid && (rsp_status == ST_RANGE),
        (rsp_value == {VAL_W{1'b1}}) || (rsp_value == 64'h0000_0000_FFFF_FFFF))

endmodule

bind string_to_integer_parser_unit stoi_port_checker u_stoi_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_last       (req.last),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_negative   (rsp.negative),
    .rsp_value      (rsp.value),
    .rsp_status     (rsp.status),
    .rsp_end_offset (rsp.end_offset)
);
